[rtl/core/cbf_pkg.sv]
`timescale 1ns / 1ps

// Shared constants and types for the cross blur filter
package cbf_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF    = 512;
  localparam int CHANNEL_BITS_DEF = 16;

  // Fixed field widths
  localparam int NUM_CH    = 3;
  localparam int ROW_W     = 12;
  localparam int COLUMN_W  = 9;
  localparam int FW_W      = 10;
  localparam int FH_W      = 12;
  localparam int WEIGHT_W  = 10;
  localparam int FRAC_BITS = 10;
  localparam int ROUND_HALF = 1 << (FRAC_BITS - 1);
  localparam int MIN_SIZE  = 3;

  // APB-style register port
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 4;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CENTER_WT    = 2'd2;
  localparam logic [1:0] REG_SIDE_WT      = 2'd3;

  // Register reset values
  localparam logic [FW_W-1:0]     FW_RST = 10'd480;
  localparam logic [FH_W-1:0]     FH_RST = 12'd360;
  localparam logic [WEIGHT_W-1:0] CW_RST = 10'd532;
  localparam logic [WEIGHT_W-1:0] SW_RST = 10'd123;

  typedef struct packed {
    logic [WEIGHT_W-1:0] center;
    logic [WEIGHT_W-1:0] side;
  } cbf_weights_t;

  // Side information carried with each pixel through the filter pipe
  typedef struct packed {
    logic [ROW_W-1:0]    row;       // row of the input that caused it
    logic [COLUMN_W-1:0] column;
    logic                border;    // pass the centre pixel through
    logic                last_row;  // input sits in the last row: two results
  } cbf_meta_t;

endpackage

[rtl/core/cbf_pix_in_if.sv]
`timescale 1ns / 1ps

// Incoming pixel channel
interface cbf_pix_in_if import cbf_pkg::*; #(
  parameter int CB = CHANNEL_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CB-1:0] red_in;
  logic [CB-1:0] green_in;
  logic [CB-1:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

[rtl/core/cbf_pix_out_if.sv]
`timescale 1ns / 1ps

// Filtered pixel channel
interface cbf_pix_out_if import cbf_pkg::*; #(
  parameter int CB = CHANNEL_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [CB-1:0]       red_out;
  logic [CB-1:0]       green_out;
  logic [CB-1:0]       blue_out;
  logic [ROW_W-1:0]    out_row;
  logic [COLUMN_W-1:0] out_column;
  logic                last_of_run;

  modport source (output valid, red_out, green_out, blue_out, out_row, out_column,
                  last_of_run, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, out_row, out_column,
                  last_of_run, output ready);
endinterface

[rtl/core/cbf_line_buffer.sv]
`timescale 1ns / 1ps

// Two line stores: newer (row above) and older (two rows above).
// Newer is read at the column and the column to its right; reads are registered.
module cbf_line_buffer import cbf_pkg::*; #(
  parameter int DEPTH = MAX_WIDTH_DEF,
  parameter int PW    = NUM_CH * CHANNEL_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [PW-1:0]            newer_wdata,
  input  logic [PW-1:0]            older_wdata,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [PW-1:0]            above_r,
  output logic [PW-1:0]            right_r,
  output logic [PW-1:0]            up2_r
);
  localparam int AW = $clog2(DEPTH);

  logic [PW-1:0] newer_mem [DEPTH];
  logic [PW-1:0] older_mem [DEPTH];
  logic [AW-1:0] rd_right;

  // right-hand neighbour address; wraps past the end (value unused there)
  assign rd_right = (rd_addr == AW'(DEPTH - 1)) ? '0 : rd_addr + AW'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      newer_mem[wr_addr] <= newer_wdata;
      older_mem[wr_addr] <= older_wdata;
    end
    above_r <= newer_mem[rd_addr];
    right_r <= newer_mem[rd_right];
    up2_r   <= older_mem[rd_addr];
  end

endmodule

[rtl/core/cbf_cross_pipe.sv]
`timescale 1ns / 1ps

// Three-stage cross filter: neighbour sum, weight multiply, round/saturate.
// The last stage also serves as the output register and plays out one or
// two results per request.
module cbf_cross_pipe import cbf_pkg::*; #(
  parameter int CB = CHANNEL_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cbf_weights_t           weights,
  input  logic                   push_valid,
  output logic                   push_ready,
  input  cbf_meta_t              push_meta,
  input  logic [NUM_CH*CB-1:0]   above,
  input  logic [NUM_CH*CB-1:0]   left,
  input  logic [NUM_CH*CB-1:0]   right,
  input  logic [NUM_CH*CB-1:0]   up2,
  input  logic [NUM_CH*CB-1:0]   cur,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [NUM_CH*CB-1:0]   out_pix,
  output logic [ROW_W-1:0]       out_row,
  output logic [COLUMN_W-1:0]    out_column,
  output logic                   out_last
);
  localparam int PW  = NUM_CH * CB;
  localparam int SW  = CB + 2;              // sum of four neighbours
  localparam int PCW = CB + WEIGHT_W;       // centre product
  localparam int PSW = SW + WEIGHT_W;       // side product
  localparam int ACW = PSW + 1;             // accumulator
  localparam int QW  = ACW - FRAC_BITS;     // after dropping the fraction

  // stage 1: neighbour sums
  logic              s1_v_r;
  cbf_meta_t         s1_meta_r;
  logic [PW-1:0]     s1_above_r;
  logic [PW-1:0]     s1_cur_r;
  logic [SW-1:0]     s1_sum_r [NUM_CH];
  logic [SW-1:0]     sum_nxt  [NUM_CH];

  // stage 2: products
  logic              s2_v_r;
  cbf_meta_t         s2_meta_r;
  logic [PW-1:0]     s2_above_r;
  logic [PW-1:0]     s2_cur_r;
  logic [PCW-1:0]    s2_pc_r [NUM_CH];
  logic [PSW-1:0]    s2_ps_r [NUM_CH];

  // stage 3: results
  logic              s3_v_r;
  logic              s3_phase_r;
  cbf_meta_t         s3_meta_r;
  logic [PW-1:0]     s3_res_r;
  logic [PW-1:0]     s3_cur_r;
  logic [PW-1:0]     res_nxt;

  logic              en2, en3, s3_done, out_fire;

  // stall chain: a stage loads when empty or when it empties this cycle
  assign out_fire   = s3_v_r && out_ready;
  assign s3_done    = out_fire && (s3_phase_r || !s3_meta_r.last_row);
  assign en3        = !s3_v_r || s3_done;
  assign en2        = !s2_v_r || en3;
  assign push_ready = !s1_v_r || en2;

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum_nxt[k] = SW'(left[k*CB +: CB]) + SW'(right[k*CB +: CB])
                 + SW'(up2[k*CB +: CB])  + SW'(cur[k*CB +: CB]);
    end
  end

  // round half up, saturate to the channel maximum; border pixels pass through
  always_comb begin
    logic [ACW-1:0] acc;
    logic [QW-1:0]  q;
    for (int k = 0; k < NUM_CH; k++) begin
      acc = ACW'(s2_pc_r[k]) + ACW'(s2_ps_r[k]) + ACW'(ROUND_HALF);
      q   = acc[ACW-1:FRAC_BITS];
      if (s2_meta_r.border) begin
        res_nxt[k*CB +: CB] = s2_above_r[k*CB +: CB];
      end else if (q[QW-1:CB] != '0) begin
        res_nxt[k*CB +: CB] = '1;
      end else begin
        res_nxt[k*CB +: CB] = q[CB-1:0];
      end
    end
  end

  // valid bits and result phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      s3_v_r     <= 1'b0;
      s3_phase_r <= 1'b0;
    end else begin
      if (push_ready) begin
        s1_v_r <= push_valid;
      end
      if (en2) begin
        s2_v_r <= s1_v_r;
      end
      if (en3) begin
        s3_v_r     <= s2_v_r;
        s3_phase_r <= 1'b0;
      end else if (out_fire) begin
        s3_phase_r <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (push_ready) begin
      s1_meta_r  <= push_meta;
      s1_above_r <= above;
      s1_cur_r   <= cur;
      s1_sum_r   <= sum_nxt;
    end
    if (en2) begin
      s2_meta_r  <= s1_meta_r;
      s2_above_r <= s1_above_r;
      s2_cur_r   <= s1_cur_r;
      for (int k = 0; k < NUM_CH; k++) begin
        s2_pc_r[k] <= PCW'(weights.center) * PCW'(s1_above_r[k*CB +: CB]);
        s2_ps_r[k] <= PSW'(weights.side) * PSW'(s1_sum_r[k]);
      end
    end
    if (en3) begin
      s3_meta_r <= s2_meta_r;
      s3_res_r  <= res_nxt;
      s3_cur_r  <= s2_cur_r;
    end
  end

  // filtered pixel of the row above first, then the last-row pixel itself
  assign out_valid  = s3_v_r;
  assign out_pix    = s3_phase_r ? s3_cur_r : s3_res_r;
  assign out_row    = s3_phase_r ? s3_meta_r.row : s3_meta_r.row - ROW_W'(1);
  assign out_column = s3_meta_r.column;
  assign out_last   = s3_phase_r || !s3_meta_r.last_row;

endmodule

[rtl/core/cross_blur_filter.sv]
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_ch     in         valid/ready          red_in, green_in, blue_in
// out_ch    out        valid/ready          red_out, green_out, blue_out,
//                                           out_row, out_column, last_of_run
// cfg       in         APB psel/penable     frame_width, frame_height,
//                                           center_weight, side_weight
//
// One pixel per cycle in unless the pipe or a register write stalls it;
// results pass the sum, product and result stages. A last-row pixel gives
// two results, so out_ch then sets the rate.
// Line store reads are registered and follow the column counter; after each
// register write input is held off for one cycle while they refetch.
// Synchronous active-low reset clears counters and pipe valids, presets
// registers; line stores are not cleared. Either side may stall at any time.
module cross_blur_filter import cbf_pkg::*; #(
  parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
  parameter int CHANNEL_BITS = CHANNEL_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  cbf_pix_in_if.sink         in_ch,
  cbf_pix_out_if.source      out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = (AW + 1 > FW_W) ? AW + 1 : FW_W;
  localparam int CB = CHANNEL_BITS;
  localparam int PW = NUM_CH * CB;

  logic [FW_W-1:0]     frame_width_r;
  logic [FH_W-1:0]     frame_height_r;
  cbf_weights_t        weights_r;
  logic                stale_r;

  logic [AW-1:0]       col_r;
  logic [ROW_W-1:0]    row_r;
  logic [PW-1:0]       left_r;

  logic                cfg_wr, acc;
  logic [WW-1:0]       fw_ext, w_eff;
  logic [AW-1:0]       w_last, c_eff, col_nxt, rd_addr;
  logic [FH_W-1:0]     h_last;
  logic                last_col, last_row;
  logic [PW-1:0]       cur, above, right, up2;
  logic                push_ready;
  cbf_meta_t           push_meta;
  logic [PW-1:0]       out_pix;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      REG_CENTER_WT:    prdata = DATA_W'(weights_r.center);
      REG_SIDE_WT:      prdata = DATA_W'(weights_r.side);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r    <= FW_RST;
      frame_height_r   <= FH_RST;
      weights_r.center <= CW_RST;
      weights_r.side   <= SW_RST;
      stale_r          <= 1'b1;
    end else begin
      stale_r <= cfg_wr;
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_FRAME_WIDTH:  frame_width_r    <= pwdata[FW_W-1:0];
          REG_FRAME_HEIGHT: frame_height_r   <= pwdata[FH_W-1:0];
          REG_CENTER_WT:    weights_r.center <= pwdata[WEIGHT_W-1:0];
          REG_SIDE_WT:      weights_r.side   <= pwdata[WEIGHT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // frame size in use: width clamped to [3, MAX_WIDTH], height at least 3
  always_comb begin
    fw_ext = WW'(frame_width_r);
    if (fw_ext < WW'(MIN_SIZE)) begin
      w_eff = WW'(MIN_SIZE);
    end else if (fw_ext > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext;
    end
  end

  assign w_last   = AW'(w_eff - WW'(1));
  assign h_last   = (frame_height_r < FH_W'(MIN_SIZE)) ? FH_W'(MIN_SIZE - 1)
                                                       : frame_height_r - FH_W'(1);
  // a counter past a shrunk size counts as the last column / row
  assign last_col = (col_r >= w_last);
  assign c_eff    = last_col ? w_last : col_r;
  assign last_row = (row_r >= h_last);

  assign in_ch.ready = push_ready && !stale_r;
  assign acc         = in_ch.valid && in_ch.ready;

  assign cur = {in_ch.blue_in, in_ch.green_in, in_ch.red_in};

  // prefetch the line stores for the column the next request will use
  assign col_nxt = !acc ? col_r : (last_col ? '0 : c_eff + AW'(1));
  assign rd_addr = (col_nxt >= w_last) ? w_last : col_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      left_r <= '0;
    end else if (acc) begin
      col_r  <= col_nxt;
      left_r <= above;
      if (last_col) begin
        row_r <= last_row ? '0 : row_r + ROW_W'(1);
      end
    end
  end

  cbf_line_buffer #(
    .DEPTH (MAX_WIDTH),
    .PW    (PW)
  ) u_lines (
    .clk         (clk),
    .wr_en       (acc),
    .wr_addr     (c_eff),
    .newer_wdata (cur),
    .older_wdata (above),
    .rd_addr     (rd_addr),
    .above_r     (above),
    .right_r     (right),
    .up2_r       (up2)
  );

  // first row only fills the stores; border rows/columns pass through
  always_comb begin
    push_meta.row      = row_r;
    push_meta.column   = COLUMN_W'(c_eff);
    push_meta.border   = (row_r == ROW_W'(1)) || (c_eff == '0) || last_col;
    push_meta.last_row = last_row;
  end

  cbf_cross_pipe #(
    .CB (CB)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .weights    (weights_r),
    .push_valid (acc && (row_r != '0)),
    .push_ready (push_ready),
    .push_meta  (push_meta),
    .above      (above),
    .left       (left_r),
    .right      (right),
    .up2        (up2),
    .cur        (cur),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_pix    (out_pix),
    .out_row    (out_ch.out_row),
    .out_column (out_ch.out_column),
    .out_last   (out_ch.last_of_run)
  );

  assign out_ch.red_out   = out_pix[0*CB +: CB];
  assign out_ch.green_out = out_pix[1*CB +: CB];
  assign out_ch.blue_out  = out_pix[2*CB +: CB];

endmodule
